// ===== design/timed_event_queue_unit_assert.svh =====
// assertion macros shared by the checker of the timed event queue
// no dependencies; included by the checker file only
`ifndef TIMED_EVENT_QUEUE_UNIT_ASSERT_SVH
`define TIMED_EVENT_QUEUE_UNIT_ASSERT_SVH

// condition in the same cycle
`define TEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("teq check failed");

// condition in the next cycle
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("teq check failed");

`endif

// ===== design/teq_pkg.sv =====
// shared types, codes and word layout of the timed event queue
// no dependencies; used by every module of the block
`default_nettype none

package teq_pkg;

   localparam int DEF_DEPTH     = 16;
   localparam int DEF_TIME_BITS = 32;

   // fixed field widths of the stream words
   localparam int FIELD_TIME_BITS  = 32;
   localparam int FIELD_COUNT_BITS = 5;

   // request kinds
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_DEL   = 2'd1;
   localparam logic [1:0] REQ_RUN   = 2'd2;
   localparam logic [1:0] REQ_QUERY = 2'd3;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;

   // request word layout
   localparam int REQ_TDATA_BITS = 96;
   localparam int REQ_TIME_LSB   = 0;
   localparam int REQ_HAND_LSB   = 32;
   localparam int REQ_DATA_LSB   = 40;
   localparam int REQ_IGN_T_BIT  = 56;
   localparam int REQ_IGN_H_BIT  = 57;
   localparam int REQ_IGN_D_BIT  = 58;
   localparam int REQ_NOW_LSB    = 59;

   // result word layout
   localparam int RSP_TDATA_BITS = 64;
   localparam int RSP_HAND_LSB   = 0;
   localparam int RSP_DATA_LSB   = 8;
   localparam int RSP_NEXT_LSB   = 24;
   localparam int RSP_COUNT_LSB  = 56;
   localparam int RSP_OVF_BIT    = 61;

   typedef struct packed {
      logic [7:0]  handler;
      logic [15:0] data;
   } payload_type;

   typedef struct packed {
      logic [1:0] op;
      logic       append;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== design/teq_cell.sv =====
// one slot of the sorted event chain: time, payload and valid bit
// depends on teq_pkg
`default_nettype none

module teq_cell #(
   parameter int TIME_BITS = teq_pkg::DEF_TIME_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire teq_pkg::cell_ctl_type ctl,
   input  wire logic [TIME_BITS-1:0]  new_time,
   input  wire teq_pkg::payload_type  new_pay,
   input  wire logic [TIME_BITS-1:0]  left_time,
   input  wire teq_pkg::payload_type  left_pay,
   input  wire logic                  left_valid,
   input  wire logic                  left_keep,
   input  wire logic [TIME_BITS-1:0]  right_time,
   input  wire teq_pkg::payload_type  right_pay,
   input  wire logic                  right_valid,
   output logic [TIME_BITS-1:0]       cell_time,
   output teq_pkg::payload_type       cell_pay,
   output logic                       cell_valid,
   output logic                       cell_keep
);

   logic [TIME_BITS-1:0] time_ff, time_in;
   teq_pkg::payload_type pay_ff, pay_in;
   logic                 valid_ff, valid_in;

   // entry stays put on insert when it is not later than the new one
   assign cell_keep = valid_ff && (time_ff <= new_time);

   always_comb begin
      time_in  = time_ff;
      pay_in   = pay_ff;
      valid_in = valid_ff;
      case (ctl.op)
         teq_pkg::CELL_INSERT: begin
            if (!cell_keep) begin
               if (left_keep) begin
                  time_in  = new_time;
                  pay_in   = new_pay;
                  valid_in = 1'b1;
               end else begin
                  time_in  = left_time;
                  pay_in   = left_pay;
                  valid_in = left_valid;
               end
            end
         end
         teq_pkg::CELL_SHIFT: begin
            if (ctl.append) begin
               time_in  = new_time;
               pay_in   = new_pay;
               valid_in = 1'b1;
            end else begin
               time_in  = right_time;
               pay_in   = right_pay;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      pay_ff  <= pay_in;
   end

   assign cell_time  = time_ff;
   assign cell_pay   = pay_ff;
   assign cell_valid = valid_ff;

endmodule

`default_nettype wire

// ===== design/timed_event_queue_unit.sv =====
// Timed event queue: up to DEPTH events held in a chain of cells, sorted by due time, with
// equal times in the order they were added. Outside a rotation, cell 0 holds the earliest
// event. An add (request kind 0) inserts with every cell deciding locally whether to keep,
// take the new event or take its left neighbor; a full queue drops the add and flags
// overflow. Delete (kind 1) and run (kind 2) rotate the occupied part of the chain once
// through cell 0, one entry a cycle: delete drops matching entries on the way, run counts
// the due entries and notes the first not-due time so that every result of the run can
// report the final next_due and entry_count. Run then pops the due entries from cell 0,
// one result word per cycle while the output register can take it, the last one marked
// by rsp_tlast; with nothing due it gives one empty word. Query (kind 3) only reports
// status. One request is worked on at a time; a new one is taken once the previous one
// has put its last word in the output register. No clearing pass: only valid bits are
// reset.
// depends on teq_pkg and teq_cell
`default_nettype none

module timed_event_queue_unit #(
   parameter int DEPTH     = teq_pkg::DEF_DEPTH,
   parameter int TIME_BITS = teq_pkg::DEF_TIME_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // due_time[31:0], handler_id[39:32], data_tag[55:40], ignore_when[56],
   // ignore_handler[57], ignore_data[58], now_time[90:59], zero fill
   input  wire logic [teq_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [1:0]                         req_tuser,
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // fired_handler[7:0], fired_data[23:8], next_due[55:24], entry_count[60:56],
   // overflow[61], zero fill
   output logic [teq_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   // fired[0]
   output logic                                    rsp_tuser,
   // last_result
   output logic                                    rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int FT = teq_pkg::FIELD_TIME_BITS;
   localparam int FC = teq_pkg::FIELD_COUNT_BITS;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_ROTATE = 3'd2;
   localparam logic [2:0] ST_POP    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        steps_ff, steps_in;
   logic [CW-1:0]        fire_ff, fire_in;
   logic                 found_ff, found_in;
   logic [TIME_BITS-1:0] capt_ff, capt_in;
   logic                 ovf_ff, ovf_in;

   // latched request
   logic [1:0]           kind_ff;
   logic [TIME_BITS-1:0] when_ff;
   logic [TIME_BITS-1:0] now_ff;
   teq_pkg::payload_type rpay_ff;
   logic                 ign_t_ff, ign_h_ff, ign_d_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   teq_pkg::payload_type rsp_pay_ff, rsp_pay_in;
   logic [FT-1:0]        rsp_next_ff, rsp_next_in;
   logic [FC-1:0]        rsp_count_ff, rsp_count_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // chain
   logic [TIME_BITS-1:0]  cell_time [DEPTH];
   teq_pkg::payload_type  cell_pay [DEPTH];
   logic                  cell_valid [DEPTH];
   logic                  cell_keep [DEPTH];
   teq_pkg::cell_ctl_type cell_ctl [DEPTH];

   logic [1:0]           cell_op;
   logic                 rot_append;
   logic [CW-1:0]        app_cnt;
   logic [IW-1:0]        app_idx;
   logic [TIME_BITS-1:0] bcast_time;
   teq_pkg::payload_type bcast_pay;

   logic [TIME_BITS-1:0] in_when, in_now;
   logic [TIME_BITS-1:0] head_nd, nd_sel;
   logic [FT-1:0]        nd_field;
   logic [FC-1:0]        count_field;
   logic                 head_due, head_hit, rsp_free, req_accept, full;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == CW'(DEPTH));

   // times taken modulo 2^TIME_BITS, reported in 32 bits
   if (TIME_BITS <= FT) begin : g_time_narrow
      assign in_when  = req_tdata[teq_pkg::REQ_TIME_LSB +: TIME_BITS];
      assign in_now   = req_tdata[teq_pkg::REQ_NOW_LSB +: TIME_BITS];
      assign nd_field = FT'(nd_sel);
   end else begin : g_time_wide
      assign in_when  = TIME_BITS'(req_tdata[teq_pkg::REQ_TIME_LSB +: FT]);
      assign in_now   = TIME_BITS'(req_tdata[teq_pkg::REQ_NOW_LSB +: FT]);
      assign nd_field = nd_sel[FT-1:0];
   end

   if (CW >= FC) begin : g_count_wide
      assign count_field = count_ff[FC-1:0];
   end else begin : g_count_narrow
      assign count_field = FC'(count_ff);
   end

   // head of the chain
   assign head_nd  = cell_valid[0] ? cell_time[0] : '1;
   assign nd_sel   = (state_ff == ST_POP) ? capt_ff : head_nd;
   assign head_due = cell_valid[0] && (cell_time[0] <= now_ff);
   assign head_hit = (ign_t_ff || (cell_time[0] == when_ff)) &&
                     (ign_h_ff || (cell_pay[0].handler == rpay_ff.handler)) &&
                     (ign_d_ff || (cell_pay[0].data == rpay_ff.data));

   // new entries come from the request on add, from the head while rotating
   assign bcast_time = (state_ff == ST_EXEC) ? when_ff : cell_time[0];
   assign bcast_pay  = (state_ff == ST_EXEC) ? rpay_ff : cell_pay[0];
   assign app_cnt    = count_ff - CW'(1);
   assign app_idx    = app_cnt[IW-1:0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_ctl[i].op     = cell_op;
      assign cell_ctl[i].append = rot_append && (app_idx == IW'(i));

      if (i == 0) begin : g_first
         if (DEPTH > 1) begin : g_more
            teq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
               .clock(clock), .reset(reset), .ctl(cell_ctl[i]),
               .new_time(bcast_time), .new_pay(bcast_pay),
               .left_time(bcast_time), .left_pay(bcast_pay),
               .left_valid(1'b1), .left_keep(1'b1),
               .right_time(cell_time[i+1]), .right_pay(cell_pay[i+1]),
               .right_valid(cell_valid[i+1]),
               .cell_time(cell_time[i]), .cell_pay(cell_pay[i]),
               .cell_valid(cell_valid[i]), .cell_keep(cell_keep[i]));
         end
      end else if (i == DEPTH - 1) begin : g_last
         teq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .reset(reset), .ctl(cell_ctl[i]),
            .new_time(bcast_time), .new_pay(bcast_pay),
            .left_time(cell_time[i-1]), .left_pay(cell_pay[i-1]),
            .left_valid(cell_valid[i-1]), .left_keep(cell_keep[i-1]),
            .right_time(bcast_time), .right_pay(bcast_pay),
            .right_valid(1'b0),
            .cell_time(cell_time[i]), .cell_pay(cell_pay[i]),
            .cell_valid(cell_valid[i]), .cell_keep(cell_keep[i]));
      end else begin : g_mid
         teq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .reset(reset), .ctl(cell_ctl[i]),
            .new_time(bcast_time), .new_pay(bcast_pay),
            .left_time(cell_time[i-1]), .left_pay(cell_pay[i-1]),
            .left_valid(cell_valid[i-1]), .left_keep(cell_keep[i-1]),
            .right_time(cell_time[i+1]), .right_pay(cell_pay[i+1]),
            .right_valid(cell_valid[i+1]),
            .cell_time(cell_time[i]), .cell_pay(cell_pay[i]),
            .cell_valid(cell_valid[i]), .cell_keep(cell_keep[i]));
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      steps_in   = steps_ff;
      fire_in    = fire_ff;
      found_in   = found_ff;
      capt_in    = capt_ff;
      ovf_in     = ovf_ff;
      cell_op    = teq_pkg::CELL_HOLD;
      rot_append = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ovf_in   = (kind_ff == teq_pkg::REQ_ADD) && full;
            steps_in = count_ff;
            fire_in  = '0;
            found_in = 1'b0;
            capt_in  = '1;
            state_in = ST_DONE;
            case (kind_ff)
               teq_pkg::REQ_ADD: begin
                  if (!full) begin
                     cell_op  = teq_pkg::CELL_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end
               teq_pkg::REQ_DEL, teq_pkg::REQ_RUN: begin
                  if (count_ff != '0) begin
                     state_in = ST_ROTATE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ROTATE: begin
            // head leaves cell 0 and comes back at the tail unless it is deleted
            cell_op = teq_pkg::CELL_SHIFT;
            if (kind_ff == teq_pkg::REQ_DEL) begin
               rot_append = !head_hit;
               if (head_hit) begin
                  count_in = count_ff - CW'(1);
               end
            end else begin
               rot_append = 1'b1;
               if (head_due) begin
                  fire_in = fire_ff + CW'(1);
               end else if (!found_ff) begin
                  found_in = 1'b1;
                  capt_in  = cell_time[0];
               end
            end
            steps_in = steps_ff - CW'(1);
            if (steps_ff == CW'(1)) begin
               state_in = ST_DONE;
               if ((kind_ff == teq_pkg::REQ_RUN) && (fire_in != '0)) begin
                  count_in = count_ff - fire_in;
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (rsp_free) begin
               cell_op      = teq_pkg::CELL_SHIFT;
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b1;
               rsp_pay_in   = cell_pay[0];
               rsp_last_in  = (fire_ff == CW'(1));
               rsp_next_in  = nd_field;
               rsp_count_in = count_field;
               rsp_ovf_in   = 1'b0;
               fire_in      = fire_ff - CW'(1);
               if (fire_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b0;
               rsp_pay_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_next_in  = nd_field;
               rsp_count_in = count_field;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         fire_ff      <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         fire_ff      <= fire_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      capt_ff      <= capt_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (req_accept) begin
         kind_ff         <= req_tuser;
         when_ff         <= in_when;
         now_ff          <= in_now;
         rpay_ff.handler <= req_tdata[teq_pkg::REQ_HAND_LSB +: 8];
         rpay_ff.data    <= req_tdata[teq_pkg::REQ_DATA_LSB +: 16];
         ign_t_ff        <= req_tdata[teq_pkg::REQ_IGN_T_BIT];
         ign_h_ff        <= req_tdata[teq_pkg::REQ_IGN_H_BIT];
         ign_d_ff        <= req_tdata[teq_pkg::REQ_IGN_D_BIT];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_ovf_ff, rsp_count_ff, rsp_next_ff,
                        rsp_pay_ff.data, rsp_pay_ff.handler};

endmodule

`default_nettype wire

// ===== design/teq_checker.sv =====
// port-level checks of the timed event queue, bound to the top level
// depends on teq_pkg and timed_event_queue_unit_assert.svh
`default_nettype none
`include "timed_event_queue_unit_assert.svh"

module teq_checker #(
   parameter int DEPTH = teq_pkg::DEF_DEPTH
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [teq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tlast
);

   logic [teq_pkg::FIELD_COUNT_BITS-1:0] word_count;
   logic                                 word_ovf;

   assign word_count = rsp_tdata[teq_pkg::RSP_COUNT_LSB +: teq_pkg::FIELD_COUNT_BITS];
   assign word_ovf   = rsp_tdata[teq_pkg::RSP_OVF_BIT];

   // a stalled result word holds
   `TEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // only fired events may be followed by more words of the same request
   `TEQ_ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)

   // no new request while a run is still delivering its events
   `TEQ_ASSERT_IMPLY(a_no_req_mid_run, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   // overflow only on an empty word, and the count never exceeds the depth
   `TEQ_ASSERT_IMPLY(a_ovf_count, clock, reset, rsp_tvalid,
      (!word_ovf || !rsp_tuser) && ((DEPTH >= 32) || (word_count <= 5'(DEPTH))))

endmodule

bind timed_event_queue_unit teq_checker #(.DEPTH(DEPTH)) u_teq_checker (.*);

`default_nettype wire

// ===== verif/timed_event_queue_unit_tb.sv =====
// self-checking bench for the timed event queue: a directed opening, then random requests
// checked word by word against a sorted-list model kept inside the bench
// depends on teq_pkg and the timed_event_queue_unit design files
`default_nettype none

module timed_event_queue_unit_tb;

   localparam int SLOTS        = teq_pkg::DEF_DEPTH;
   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 200;    // long receiver hold-off, block fills and stalls

   // one request as the sender sees it
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] due;
      logic [7:0]  hand;
      logic [15:0] data;
      logic        ign_t;
      logic        ign_h;
      logic        ign_d;
      logic [31:0] now;
   } event_req_type;

   // one result word, split into its fields
   typedef struct {
      logic        fired;
      logic [7:0]  hand;
      logic [15:0] data;
      logic        last;
      logic [31:0] next_due;
      logic [4:0]  count;
      logic        ovf;
   } event_word_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [teq_pkg::REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]                         req_tuser  = teq_pkg::REQ_QUERY;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [teq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tlast;

   timed_event_queue_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // requests waiting to be offered, and the request now on the bus
   event_req_type  pending_reqs[$];
   event_req_type  req_cur;
   logic           req_took = 1'b0;

   // words the queue model says must come back, oldest first
   event_word_type awaited_words[$];

   int items_sent  = 0;
   int items_taken = 0;
   int words_seen  = 0;
   int mismatches  = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   logic hold_done = 1'b0;

   // ---------------------------------------------------------------------------------------
   // queue model: slots 0 .. ev_len-1 hold the events in firing order
   // ---------------------------------------------------------------------------------------
   logic [31:0] ev_time [SLOTS];
   logic [7:0]  ev_hand [SLOTS];
   logic [15:0] ev_data [SLOTS];
   int          ev_len = 0;

   // status fields always reflect the model after the whole request
   function automatic void push_word(logic fired, logic [7:0] hand, logic [15:0] data,
                                     logic last, logic ovf);
      event_word_type w;
      w.fired    = fired;
      w.hand     = hand;
      w.data     = data;
      w.last     = last;
      w.next_due = (ev_len > 0) ? ev_time[0] : '1;
      w.count    = 5'(ev_len);
      w.ovf      = ovf;
      awaited_words.push_back(w);
   endfunction

   function automatic void apply_request(event_req_type r);
      int pos;
      int keep;
      int n;
      logic hit;
      logic [7:0]  fired_hand [SLOTS];
      logic [15:0] fired_data [SLOTS];
      case (r.kind)
         teq_pkg::REQ_ADD: begin
            if (ev_len >= SLOTS) begin
               // full: dropped, state untouched
               push_word(1'b0, '0, '0, 1'b1, 1'b1);
            end else begin
               // equal times go behind the ones already queued
               pos = 0;
               while (pos < ev_len && ev_time[pos] <= r.due) pos++;
               for (int i = ev_len; i > pos; i--) begin
                  ev_time[i] = ev_time[i-1];
                  ev_hand[i] = ev_hand[i-1];
                  ev_data[i] = ev_data[i-1];
               end
               ev_time[pos] = r.due;
               ev_hand[pos] = r.hand;
               ev_data[pos] = r.data;
               ev_len++;
               push_word(1'b0, '0, '0, 1'b1, 1'b0);
            end
         end
         teq_pkg::REQ_DEL: begin
            keep = 0;
            for (int i = 0; i < ev_len; i++) begin
               hit = (r.ign_t || ev_time[i] == r.due) &&
                     (r.ign_h || ev_hand[i] == r.hand) &&
                     (r.ign_d || ev_data[i] == r.data);
               if (!hit) begin
                  ev_time[keep] = ev_time[i];
                  ev_hand[keep] = ev_hand[i];
                  ev_data[keep] = ev_data[i];
                  keep++;
               end
            end
            ev_len = keep;
            push_word(1'b0, '0, '0, 1'b1, 1'b0);
         end
         teq_pkg::REQ_RUN: begin
            n = 0;
            while (n < ev_len && ev_time[n] <= r.now) begin
               fired_hand[n] = ev_hand[n];
               fired_data[n] = ev_data[n];
               n++;
            end
            if (n == 0) begin
               push_word(1'b0, '0, '0, 1'b1, 1'b0);
            end else begin
               for (int i = n; i < ev_len; i++) begin
                  ev_time[i-n] = ev_time[i];
                  ev_hand[i-n] = ev_hand[i];
                  ev_data[i-n] = ev_data[i];
               end
               ev_len -= n;
               for (int i = 0; i < n; i++)
                  push_word(1'b1, fired_hand[i], fired_data[i], i == n - 1, 1'b0);
            end
         end
         default: begin
            push_word(1'b0, '0, '0, 1'b1, 1'b0);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("word %0d %s: got %0h, expected %0h", words_seen, what, got, want);
   endtask

   function automatic event_req_type make_req(logic [1:0] kind, logic [31:0] due,
                                              logic [7:0] hand, logic [15:0] data,
                                              logic [2:0] ign, logic [31:0] now);
      event_req_type r;
      r.kind  = kind;
      r.due   = due;
      r.hand  = hand;
      r.data  = data;
      r.ign_t = ign[0];
      r.ign_h = ign[1];
      r.ign_d = ign[2];
      r.now   = now;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // request driver: changes on the falling edge, one nonblocking write of tvalid per step
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      logic offer;
      event_req_type nxt;
      logic [teq_pkg::REQ_TDATA_BITS-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // a word not taken at the last rising edge stays on the bus
         offer = req_tvalid && !req_took;
         if (!offer && pending_reqs.size() != 0 &&
             (($urandom_range(0, 99) >= 29) || (items_sent >= 40 && items_sent < 70))) begin
            nxt = pending_reqs.pop_front();
            word = '0;
            word[teq_pkg::REQ_TIME_LSB +: 32] = nxt.due;
            word[teq_pkg::REQ_HAND_LSB +: 8]  = nxt.hand;
            word[teq_pkg::REQ_DATA_LSB +: 16] = nxt.data;
            word[teq_pkg::REQ_IGN_T_BIT]      = nxt.ign_t;
            word[teq_pkg::REQ_IGN_H_BIT]      = nxt.ign_h;
            word[teq_pkg::REQ_IGN_D_BIT]      = nxt.ign_d;
            word[teq_pkg::REQ_NOW_LSB +: 32]  = nxt.now;
            req_cur   <= nxt;
            req_tdata <= word;
            req_tuser <= nxt.kind;
            items_sent <= items_sent + 1;
            offer = 1'b1;
         end
         req_tvalid <= offer;
      end
   end

   // ---------------------------------------------------------------------------------------
   // result receiver: random stalls, one long hold-off, a calm stretch with no stalls
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && words_seen >= 40) begin
         // sender keeps offering meanwhile, so the input side backs up
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (words_seen >= 60 && words_seen < 100) ||
                       ($urandom_range(0, 99) >= 29);
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: samples both handshakes at the rising edge, predicts, checks, times out
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      event_word_type want;
      cycle_count <= cycle_count + 1;
      req_took    <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         apply_request(req_cur);
         items_taken <= items_taken + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen <= words_seen + 1;
         if (awaited_words.size() == 0) begin
            report_mismatch("with nothing awaited, count",
                            32'(rsp_tdata[teq_pkg::RSP_COUNT_LSB +: 5]), '0);
         end else begin
            want = awaited_words.pop_front();
            if (rsp_tuser !== want.fired)
               report_mismatch("fired", 32'(rsp_tuser), 32'(want.fired));
            if (rsp_tdata[teq_pkg::RSP_HAND_LSB +: 8] !== want.hand)
               report_mismatch("handler", 32'(rsp_tdata[teq_pkg::RSP_HAND_LSB +: 8]),
                               32'(want.hand));
            if (rsp_tdata[teq_pkg::RSP_DATA_LSB +: 16] !== want.data)
               report_mismatch("data", 32'(rsp_tdata[teq_pkg::RSP_DATA_LSB +: 16]),
                               32'(want.data));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            if (rsp_tdata[teq_pkg::RSP_NEXT_LSB +: 32] !== want.next_due)
               report_mismatch("next_due", rsp_tdata[teq_pkg::RSP_NEXT_LSB +: 32],
                               want.next_due);
            if (rsp_tdata[teq_pkg::RSP_COUNT_LSB +: 5] !== want.count)
               report_mismatch("count", 32'(rsp_tdata[teq_pkg::RSP_COUNT_LSB +: 5]),
                               32'(want.count));
            if (rsp_tdata[teq_pkg::RSP_OVF_BIT] !== want.ovf)
               report_mismatch("overflow", 32'(rsp_tdata[teq_pkg::RSP_OVF_BIT]),
                               32'(want.ovf));
         end
      end
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timed_event_queue_unit: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------------
   initial begin
      event_req_type recent_adds[$];
      event_req_type pick;
      logic [31:0]   stim_now;
      logic [31:0]   due;
      logic [7:0]    hand;
      logic [15:0]   data;
      int            k;
      int            sel;
      int            total_items;

      // directed: empty queue status, empty run, delete on empty
      pending_reqs.push_back(make_req(teq_pkg::REQ_QUERY, '0, '0, '0, 3'b000, '0));
      pending_reqs.push_back(make_req(teq_pkg::REQ_RUN, '0, '0, '0, 3'b000, '1));
      pending_reqs.push_back(make_req(teq_pkg::REQ_DEL, '0, '0, '0, 3'b111, '0));
      // field extremes, then two events sharing one due time
      pending_reqs.push_back(make_req(teq_pkg::REQ_ADD, '0, '0, '0, 3'b000, '0));
      pending_reqs.push_back(make_req(teq_pkg::REQ_ADD, '1, '1, '1, 3'b000, '0));
      pending_reqs.push_back(make_req(teq_pkg::REQ_ADD, 32'd100, 8'h01, 16'h1111, 3'b000,
                                      '0));
      pending_reqs.push_back(make_req(teq_pkg::REQ_ADD, 32'd100, 8'h02, 16'h2222, 3'b000,
                                      '0));
      // partial run fires only the time-zero event
      pending_reqs.push_back(make_req(teq_pkg::REQ_RUN, '0, '0, '0, 3'b000, 32'd99));
      // exact delete of the all-ones event, then one with the handler ignored
      pending_reqs.push_back(make_req(teq_pkg::REQ_DEL, '1, '1, '1, 3'b000, '0));
      pending_reqs.push_back(make_req(teq_pkg::REQ_DEL, 32'd100, 8'h55, 16'h2222, 3'b010,
                                      '0));
      // fill to the brim with many equal times, then one add too many
      repeat (SLOTS) begin
         sel = $urandom_range(0, 3);
         due = (sel == 0) ? 32'd0 : (sel == 3) ? 32'd200 : 32'd100;
         pending_reqs.push_back(make_req(teq_pkg::REQ_ADD, due, 8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 65535)), 3'b000, '0));
      end
      // run at the latest time drains everything, sixteen words
      pending_reqs.push_back(make_req(teq_pkg::REQ_RUN, '0, '0, '0, 3'b000, '1));

      // random part: mostly adds near the running time, runs that move time on,
      // deletes aimed at recently added events, two bursts that overflow the queue
      stim_now = 32'd1000;
      for (int i = 0; i < 40; i++) begin
         if (i == 10 || i == 30) begin
            repeat (SLOTS + 2)
               pending_reqs.push_back(make_req(teq_pkg::REQ_ADD,
                                               stim_now + 32'($urandom_range(0, 40)),
                                               8'($urandom_range(0, 255)),
                                               16'($urandom_range(0, 65535)),
                                               3'b000, '0));
         end
         k = $urandom_range(0, 99);
         if (k < 45) begin
            sel = $urandom_range(0, 9);
            due = (sel == 0) ? $urandom() : (sel == 1) ? stim_now :
                  (sel == 2) ? '1 : stim_now + 32'($urandom_range(0, 300));
            // narrow values half the time so deletes and equal times collide
            hand = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            data = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                        : 16'($urandom_range(0, 65535));
            pick = make_req(teq_pkg::REQ_ADD, due, hand, data, 3'($urandom_range(0, 7)),
                            $urandom());
            recent_adds.push_back(pick);
            if (recent_adds.size() > 24) void'(recent_adds.pop_front());
            pending_reqs.push_back(pick);
         end else if (k < 60) begin
            if (recent_adds.size() != 0 && $urandom_range(0, 3) != 0) begin
               pick = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
               pending_reqs.push_back(make_req(teq_pkg::REQ_DEL, pick.due, pick.hand,
                                               pick.data, 3'($urandom_range(0, 7)),
                                               $urandom()));
            end else begin
               pending_reqs.push_back(make_req(teq_pkg::REQ_DEL, $urandom(),
                                               8'($urandom_range(0, 255)),
                                               16'($urandom_range(0, 65535)),
                                               3'($urandom_range(0, 7)), $urandom()));
            end
         end else if (k < 88) begin
            sel = $urandom_range(0, 9);
            stim_now = stim_now + 32'($urandom_range(0, 250));
            pending_reqs.push_back(make_req(teq_pkg::REQ_RUN, $urandom(),
                                            8'($urandom_range(0, 255)),
                                            16'($urandom_range(0, 65535)),
                                            3'($urandom_range(0, 7)),
                                            (sel == 0) ? '1 : (sel == 1) ? $urandom()
                                                                         : stim_now));
         end else begin
            pending_reqs.push_back(make_req(teq_pkg::REQ_QUERY, $urandom(),
                                            8'($urandom_range(0, 255)),
                                            16'($urandom_range(0, 65535)),
                                            3'($urandom_range(0, 7)), $urandom()));
         end
      end
      total_items = pending_reqs.size();

      // reset held, then released on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every request is taken and every awaited word has come back
      while (items_taken < total_items || awaited_words.size() != 0) @(negedge clock);
      // keep running for a while so a stray extra word would still be caught
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("timed_event_queue_unit: match");
      else
         $display("timed_event_queue_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
